@@ rtl/bqd_pkg.sv @@
// bandwidth quota distributor package: widths, action and status codes, fsm states
// no dependencies
package bqd_pkg;
    localparam int Nodes = 32;
    localparam int NW = 5;
    localparam int LW = 6;
    localparam logic [LW-1:0] END_MARK = LW'(Nodes);
    localparam logic [20:0] MIN_CHUNK_RST = 21'(2 << 10);
    localparam logic [20:0] MAX_CHUNK_RST = 21'(16 << 10);

    localparam logic [3:0] ACT_ENABLE = 4'd0;
    localparam logic [3:0] ACT_DISABLE = 4'd1;
    localparam logic [3:0] ACT_TICK = 4'd2;
    localparam logic [3:0] ACT_QUERY = 4'd3;
    localparam logic [3:0] ACT_USED = 4'd4;
    localparam logic [3:0] ACT_USED_UNTHR = 4'd5;
    localparam logic [3:0] ACT_DEACT = 4'd6;
    localparam logic [3:0] ACT_INSERT = 4'd7;
    localparam logic [3:0] ACT_ERASE = 4'd8;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_ENABLED = 3'd1;
    localparam logic [2:0] ST_INACTIVE = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_OVERUSE = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;
    localparam logic [2:0] ST_MISMATCH = 3'd6;
    localparam logic [2:0] ST_BAD_SPLIT = 3'd7;

    localparam logic [0:0] CFG_MIN = 1'b0;
    localparam logic [0:0] CFG_MAX = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_CLEAR, S_DIS_RD, S_DIS_WAIT, S_DIS_EMIT,
        S_TK_RD, S_TK_WAIT, S_TK_CHK, S_TK_FIN,
        S_ACT_RD, S_ACT_WAIT, S_ACT_CHK,
        S_Q_RD, S_Q_WAIT, S_Q_FIN,
        S_USE_RD, S_USE_WAIT, S_USE_FIN,
        S_RD_N, S_WAIT_N, S_LNK, S_LNK2,
        S_ER_WAIT, S_ER_FIN, S_INS_FIN, S_DONE
    } t_state;

    // one memory access: read or write of a flow entry
    typedef struct packed {
        logic            rd;
        logic            wr_q;
        logic            wr_n;
        logic            wr_p;
        logic [NW-1:0]   addr;
        logic [31:0]     q;
        logic [LW-1:0]   nxt;
        logic [LW-1:0]   prv;
    } t_mem_req;

    typedef struct packed {
        logic [31:0]   q;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } t_mem_rd;
endpackage

@@ rtl/bqd_flow_mem.sv @@
// flow table memory: quota, next and previous link per flow, registered read
// depends on bqd_pkg
module bqd_flow_mem (
    input  logic              i_clk,
    input  bqd_pkg::t_mem_req i_req,
    output bqd_pkg::t_mem_rd  o_rd
);
    logic [31:0]             r_q_mem [bqd_pkg::Nodes];
    logic [bqd_pkg::LW-1:0]  r_n_mem [bqd_pkg::Nodes];
    logic [bqd_pkg::LW-1:0]  r_p_mem [bqd_pkg::Nodes];
    bqd_pkg::t_mem_rd        r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_q) r_q_mem[i_req.addr] <= i_req.q;
        if (i_req.wr_n) r_n_mem[i_req.addr] <= i_req.nxt;
        if (i_req.wr_p) r_p_mem[i_req.addr] <= i_req.prv;
        if (i_req.rd) begin
            r_rd.q   <= r_q_mem[i_req.addr];
            r_rd.nxt <= r_n_mem[i_req.addr];
            r_rd.prv <= r_p_mem[i_req.addr];
        end
    end
    assign o_rd = r_rd;
endmodule

@@ rtl/bandwidth_quota_distributor_top.sv @@
// bandwidth quota distributor top: command sequencer around the flow table memory
// depends on bqd_pkg, bqd_flow_mem
//
// channel  | signals                                          | handshake
// command  | i_action i_node i_amount                         | i_start & !o_busy
// result   | o_status o_value o_activated o_activated_node o_last | o_valid, one cycle
// config   | i_cfg_we i_cfg_idx i_cfg_data                    | i_cfg_we
//
// simple actions finish straight from decode; a use report, erase and insert do
// read-modify-write through the one-port flow memory with a registered read. a tick
// walks the waiting flows from the split point, disable clears every flow quota and
// then walks the waiting flows, and query/deactivate walk the active list flow by flow.
// reset is synchronous; the flow quota table is cleared by the disable sweep
// and by insert, so no clearing pass follows reset. results cannot be stalled.
module bandwidth_quota_distributor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [3:0]  i_action,
    input  logic [4:0]  i_node,
    input  logic [31:0] i_amount,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    output logic        o_busy,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic signed [32:0] o_value,
    output logic        o_activated,
    output logic [4:0]  o_activated_node,
    output logic        o_last
);
    localparam int NW = bqd_pkg::NW;
    localparam int LW = bqd_pkg::LW;
    localparam logic [LW-1:0] EM = bqd_pkg::END_MARK;

    bqd_pkg::t_state r_state, n_state;
    logic [20:0] r_min, r_max;
    logic        r_en, n_en;
    logic [bqd_pkg::Nodes-1:0] r_listed, n_listed;
    logic [LW-1:0] r_head, n_head, r_tail, n_tail, r_split, n_split, r_cnt, n_cnt;
    logic [31:0] r_out, n_out, r_unal, n_unal, r_unth, n_unth;
    logic [3:0]  r_act;
    logic [NW-1:0] r_node;
    logic [31:0] r_amt;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_sv, n_sv;   // saved link of the target
    logic [LW-1:0] r_sp, n_sp;
    logic [LW-1:0] r_step, n_step;
    logic [31:0] r_tq, n_tq;
    logic          r_ov, n_ov;
    logic [2:0]    r_ost, n_ost;
    logic [32:0]   r_oval, n_oval;
    logic          r_oact, n_oact;
    logic [NW-1:0] r_onode, n_onode;
    logic          r_olast, n_olast;

    bqd_pkg::t_mem_req mreq;
    bqd_pkg::t_mem_rd  mrd;

    bqd_flow_mem u_mem (.i_clk(i_clk), .i_req(mreq), .o_rd(mrd));

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    logic valid_n, listed_n;
    logic [31:0] tu_add, tu_gap;
    logic [31:0] q_min, u_rest, u_sub;
    logic [32:0] q_sum;
    logic [31:0] q_sat;
    logic [32:0] t_used;

    assign valid_n  = ({1'b0, r_node} < LW'(bqd_pkg::Nodes));
    assign listed_n = valid_n && r_listed[r_node];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= bqd_pkg::MIN_CHUNK_RST;
            r_max <= bqd_pkg::MAX_CHUNK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bqd_pkg::CFG_MIN: r_min <= i_cfg_data;
                bqd_pkg::CFG_MAX: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bqd_pkg::S_IDLE;
            r_en <= 1'b0;
            r_listed <= '0;
            r_head <= EM;
            r_tail <= EM;
            r_split <= EM;
            r_cnt <= '0;
            r_out <= '0;
            r_unal <= '0;
            r_unth <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_en <= n_en;
            r_listed <= n_listed;
            r_head <= n_head;
            r_tail <= n_tail;
            r_split <= n_split;
            r_cnt <= n_cnt;
            r_out <= n_out;
            r_unal <= n_unal;
            r_unth <= n_unth;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_act <= i_action;
            r_node <= i_node;
            r_amt <= i_amount;
        end
        r_cur <= n_cur;
        r_sv <= n_sv;
        r_sp <= n_sp;
        r_step <= n_step;
        r_tq <= n_tq;
        r_ost <= n_ost;
        r_oval <= n_oval;
        r_oact <= n_oact;
        r_onode <= n_onode;
        r_olast <= n_olast;
    end

    // top-up of quota r_tq (held in mrd.q path via r_tq), use-report, query and tick sums
    always_comb begin
        tu_gap = ({11'd0, r_max} > r_tq) ? ({11'd0, r_max} - r_tq) : 32'd0;
        tu_add = (tu_gap > r_unal) ? r_unal : tu_gap;
        if (r_tq >= {11'd0, r_min}) tu_add = 32'd0;
        q_min  = (r_amt < mrd.q) ? r_amt : mrd.q;
        u_rest = r_amt - q_min;
        u_sub  = (u_rest < r_unal) ? u_rest : r_unal;
        q_sum  = {1'b0, mrd.q} + {1'b0, r_unal};
        q_sat  = q_sum[32] ? 32'hFFFF_FFFF : q_sum[31:0];
        t_used = {1'b0, r_amt} - ({1'b0, r_unal} - {1'b0, r_amt});
    end

    always_comb begin
        n_state = r_state;
        n_en = r_en; n_listed = r_listed; n_head = r_head; n_tail = r_tail;
        n_split = r_split; n_cnt = r_cnt; n_out = r_out; n_unal = r_unal;
        n_unth = r_unth; n_cur = r_cur; n_sv = r_sv; n_sp = r_sp;
        n_step = r_step; n_tq = r_tq;
        n_ov = 1'b0; n_ost = bqd_pkg::ST_OK; n_oval = '0; n_oact = 1'b0;
        n_onode = '0; n_olast = 1'b0;
        mreq = '0;
        mreq.addr = r_node;

        case (r_state)
            bqd_pkg::S_IDLE: begin
                if (i_start) n_state = bqd_pkg::S_DECODE;
            end
            bqd_pkg::S_DECODE: begin
                n_state = bqd_pkg::S_DONE;
                case (r_act)
                    bqd_pkg::ACT_ENABLE: begin
                        if (!r_en && r_cnt != '0 && r_split == r_head)
                            n_ost = bqd_pkg::ST_BAD_SPLIT;
                        else n_en = 1'b1;
                        n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                    end
                    bqd_pkg::ACT_DISABLE: begin
                        if (r_en) begin
                            n_en = 1'b0; n_out = '0; n_unal = '0; n_unth = '0;
                            n_step = '0; n_state = bqd_pkg::S_CLEAR;
                        end else begin
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end
                    end
                    bqd_pkg::ACT_TICK: begin
                        if (!r_en) begin
                            n_ost = bqd_pkg::ST_NOT_ENABLED;
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end else begin
                            n_unal = sat_add(r_unal, r_unth);
                            n_unth = r_amt;
                            n_step = '0;
                            n_state = bqd_pkg::S_TK_RD;
                        end
                    end
                    bqd_pkg::ACT_QUERY, bqd_pkg::ACT_DEACT: begin
                        if (r_act == bqd_pkg::ACT_QUERY && !r_en) begin
                            n_oval = 33'd2147483647;
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end else if (!listed_n) begin
                            n_ost = bqd_pkg::ST_NOT_FOUND;
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end else begin
                            n_cur = r_head; n_step = '0;
                            n_state = bqd_pkg::S_ACT_RD;
                        end
                    end
                    bqd_pkg::ACT_USED: begin
                        if (r_amt == '0 || !r_en || !listed_n) begin
                            n_oval = {1'b0, r_amt};
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end else n_state = bqd_pkg::S_USE_RD;
                    end
                    bqd_pkg::ACT_USED_UNTHR: begin
                        n_unth = r_unth - ((r_amt < r_unth) ? r_amt : r_unth);
                        n_unal = r_unal - (((r_amt - ((r_amt < r_unth) ? r_amt : r_unth))
                                 < r_unal) ? (r_amt - ((r_amt < r_unth) ? r_amt : r_unth))
                                 : r_unal);
                        n_oval = {1'b0, r_amt};
                        n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                    end
                    bqd_pkg::ACT_INSERT: begin
                        if (!valid_n) begin
                            n_ost = bqd_pkg::ST_NOT_FOUND;
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end else if (listed_n) begin
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end else begin
                            n_sp = r_en ? r_split : EM;
                            n_tq = '0;
                            n_state = bqd_pkg::S_RD_N;
                        end
                    end
                    bqd_pkg::ACT_ERASE: begin
                        if (!listed_n) begin
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end else if (r_cnt == '0) begin
                            n_ost = bqd_pkg::ST_EMPTY;
                            n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                        end else begin
                            mreq.rd = 1'b1;
                            n_state = bqd_pkg::S_ER_WAIT;
                        end
                    end
                    default: begin
                        n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                    end
                endcase
            end
            // disable: zero every quota, then walk waiting flows
            bqd_pkg::S_CLEAR: begin
                mreq.wr_q = 1'b1; mreq.addr = r_step[NW-1:0];
                n_step = r_step + 1'b1;
                if (r_step == LW'(bqd_pkg::Nodes - 1)) begin
                    n_cur = r_split; n_step = '0; n_state = bqd_pkg::S_DIS_RD;
                end
            end
            bqd_pkg::S_DIS_RD: begin
                if (r_cur >= EM || r_step == LW'(bqd_pkg::Nodes)) begin
                    n_split = EM;
                    n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                end else begin
                    mreq.rd = 1'b1; mreq.addr = r_cur[NW-1:0];
                    n_state = bqd_pkg::S_DIS_WAIT;
                end
            end
            bqd_pkg::S_DIS_WAIT: n_state = bqd_pkg::S_DIS_EMIT;
            bqd_pkg::S_DIS_EMIT: begin
                n_ov = 1'b1; n_oact = 1'b1; n_onode = r_cur[NW-1:0];
                n_cur = mrd.nxt; n_step = r_step + 1'b1;
                n_state = bqd_pkg::S_DIS_RD;
            end
            // tick: top up waiting flows from the split point
            bqd_pkg::S_TK_RD: begin
                if (r_split >= EM || r_step == LW'(bqd_pkg::Nodes)) begin
                    n_state = bqd_pkg::S_TK_FIN;
                end else begin
                    mreq.rd = 1'b1; mreq.addr = r_split[NW-1:0];
                    n_state = bqd_pkg::S_TK_WAIT;
                end
            end
            bqd_pkg::S_TK_WAIT: begin
                n_tq = mrd.q; n_sv = mrd.nxt; n_state = bqd_pkg::S_TK_CHK;
            end
            bqd_pkg::S_TK_CHK: begin
                mreq.wr_q = 1'b1; mreq.addr = r_split[NW-1:0];
                mreq.q = r_tq + tu_add;
                n_out = sat_add(r_out, tu_add);
                n_unal = r_unal - tu_add;
                if (r_tq + tu_add < {11'd0, r_min}) begin
                    n_state = bqd_pkg::S_TK_FIN;
                end else begin
                    n_ov = 1'b1; n_oact = 1'b1; n_onode = r_split[NW-1:0];
                    n_split = r_sv; n_step = r_step + 1'b1;
                    n_state = bqd_pkg::S_TK_RD;
                end
            end
            bqd_pkg::S_TK_FIN: begin
                n_oval = {1'b0, r_amt};
                if (r_unal > r_amt) begin
                    n_oval = t_used;
                    n_unal = r_amt;
                end
                n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
            end
            // active-part walk for query and deactivate
            bqd_pkg::S_ACT_RD: begin
                if (r_cur >= EM || r_cur == r_split || r_step == LW'(bqd_pkg::Nodes)) begin
                    n_ost = bqd_pkg::ST_INACTIVE;
                    n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                end else if (r_cur[NW-1:0] == r_node) begin
                    mreq.rd = 1'b1;
                    n_state = (r_act == bqd_pkg::ACT_QUERY) ? bqd_pkg::S_Q_WAIT
                                                             : bqd_pkg::S_WAIT_N;
                end else begin
                    mreq.rd = 1'b1; mreq.addr = r_cur[NW-1:0];
                    n_state = bqd_pkg::S_ACT_WAIT;
                end
            end
            bqd_pkg::S_ACT_WAIT: n_state = bqd_pkg::S_ACT_CHK;
            bqd_pkg::S_ACT_CHK: begin
                n_cur = mrd.nxt; n_step = r_step + 1'b1; n_state = bqd_pkg::S_ACT_RD;
            end
            bqd_pkg::S_Q_WAIT: n_state = bqd_pkg::S_Q_FIN;
            bqd_pkg::S_Q_FIN: begin
                n_oval = (q_sat >= {11'd0, r_min}) ? {1'b0, q_sat} : 33'd0;
                n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
            end
            // use report
            bqd_pkg::S_USE_RD: begin
                mreq.rd = 1'b1; n_state = bqd_pkg::S_USE_WAIT;
            end
            bqd_pkg::S_USE_WAIT: n_state = bqd_pkg::S_USE_FIN;
            bqd_pkg::S_USE_FIN: begin
                if (q_min > r_out) begin
                    n_ost = bqd_pkg::ST_OVERUSE;
                end else begin
                    mreq.wr_q = 1'b1; mreq.q = mrd.q - q_min;
                    n_out = r_out - q_min;
                    n_unal = r_unal - u_sub;
                    n_oval = {1'b0, r_amt};
                end
                n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
            end
            // erase
            bqd_pkg::S_ER_WAIT: n_state = bqd_pkg::S_ER_FIN;
            bqd_pkg::S_ER_FIN: begin
                if (mrd.q > r_out) begin
                    n_ost = bqd_pkg::ST_MISMATCH;
                    n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                end else begin
                    n_out = r_out - mrd.q;
                    n_unal = sat_add(r_unal, mrd.q);
                    if (r_split[NW-1:0] == r_node && r_split < EM) n_split = mrd.nxt;
                    mreq.wr_q = 1'b1; mreq.q = '0;
                    n_listed[r_node] = 1'b0;
                    n_cnt = r_cnt - 1'b1;
                    n_sv = mrd.nxt; n_cur = mrd.prv; n_sp = EM;
                    n_step = '0;
                    n_state = bqd_pkg::S_LNK;
                end
            end
            // deactivate: node data read; unlink then append at tail
            bqd_pkg::S_WAIT_N: begin
                n_step = '0;
                n_state = bqd_pkg::S_LNK;
            end
            bqd_pkg::S_RD_N: begin
                // insert: read prev of insertion point when it is a flow
                if (r_sp < EM) begin
                    mreq.rd = 1'b1; mreq.addr = r_sp[NW-1:0];
                end
                n_state = bqd_pkg::S_INS_FIN;
            end
            bqd_pkg::S_INS_FIN: begin
                // wait state for memory data; on entry from RD_N the read data is already valid here
                n_state = bqd_pkg::S_LNK2;
                n_step = 6'd1;
            end
            bqd_pkg::S_LNK: begin
                // unlink r_node: prev = r_cur, next = r_sv (erase) or mrd (deact)
                if (r_act == bqd_pkg::ACT_DEACT && r_step == '0) begin
                    n_cur = mrd.prv; n_sv = mrd.nxt; n_step = 6'd2;
                end else if (r_step != 6'd3) begin
                    // fix prev side
                    if (r_cur >= EM) n_head = r_sv;
                    else begin
                        mreq.wr_n = 1'b1; mreq.addr = r_cur[NW-1:0]; mreq.nxt = r_sv;
                    end
                    n_step = 6'd3;
                end else begin
                    if (r_sv >= EM) n_tail = r_cur;
                    else begin
                        mreq.wr_p = 1'b1; mreq.addr = r_sv[NW-1:0]; mreq.prv = r_cur;
                    end
                    if (r_act == bqd_pkg::ACT_DEACT) begin
                        // append at tail, using the updated tail
                        n_sp = EM; n_tq = '0;
                        n_step = 6'd0;
                        n_state = bqd_pkg::S_LNK2;
                    end else begin
                        n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                    end
                end
            end
            bqd_pkg::S_LNK2: begin
                // link r_node before r_sp; step 0 means no memory read pending
                if (r_sp >= EM) begin
                    mreq.wr_p = 1'b1; mreq.wr_n = 1'b1;
                    mreq.prv = r_tail; mreq.nxt = EM;
                    if (r_tail >= EM) n_head = {1'b0, r_node};
                    n_tail = {1'b0, r_node};
                    n_cur = r_tail;
                end else begin
                    mreq.wr_p = 1'b1; mreq.wr_n = 1'b1;
                    mreq.prv = mrd.prv; mreq.nxt = r_sp;
                    if (mrd.prv >= EM) n_head = {1'b0, r_node};
                    n_cur = mrd.prv;
                end
                n_state = bqd_pkg::S_DONE;
            end
            bqd_pkg::S_DONE: begin
                // finish link fixups and the per-action tail work
                if (r_act == bqd_pkg::ACT_DEACT) begin
                    if (r_cur < EM) begin
                        mreq.wr_n = 1'b1; mreq.addr = r_cur[NW-1:0];
                        mreq.nxt = {1'b0, r_node};
                    end
                    if (r_split >= EM) n_split = {1'b0, r_node};
                    n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
                end else if (r_step != 6'd7) begin
                    // insert, first fixup
                    if (r_sp < EM) begin
                        mreq.wr_p = 1'b1; mreq.addr = r_sp[NW-1:0];
                        mreq.prv = {1'b0, r_node};
                    end
                    n_listed[r_node] = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    n_step = 6'd7;
                end else begin
                    if (r_cur < EM) begin
                        mreq.wr_n = 1'b1; mreq.addr = r_cur[NW-1:0];
                        mreq.nxt = {1'b0, r_node};
                    end
                    n_tq = '0;
                    n_state = bqd_pkg::S_Q_RD;
                end
            end
            bqd_pkg::S_Q_RD: begin
                // insert: zero quota, topped up from the unallocated pool when enabled
                mreq.wr_q = 1'b1;
                if (r_en) begin
                    mreq.q = r_tq + tu_add;
                    n_out = sat_add(r_out, tu_add);
                    n_unal = r_unal - tu_add;
                end
                n_ov = 1'b1; n_olast = 1'b1; n_state = bqd_pkg::S_IDLE;
            end
            default: n_state = bqd_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != bqd_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_value = r_oval;
    assign o_activated = r_oact;
    assign o_activated_node = r_onode;
    assign o_last = r_olast;
endmodule

@@ rtl/bqd_checker.sv @@
// port-level checks for the bandwidth quota distributor
// depends on bqd_pkg and the bandwidth_quota_distributor_top ports
module bqd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic       o_activated,
    input logic [4:0] o_activated_node,
    input logic       o_last
);
    a_act_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_activated |-> !o_last && o_status == bqd_pkg::ST_OK) else $error("act");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_busy) else $error("last");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("busy");
    a_node_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_activated |-> o_activated_node == 5'd0) else $error("node");
endmodule

bind bandwidth_quota_distributor_top bqd_checker u_bqd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_valid(o_valid), .o_status(o_status), .o_activated(o_activated),
    .o_activated_node(o_activated_node), .o_last(o_last)
);
